FILE: sv/icbc_pkg.sv
// shared types, codes and arithmetic helpers for the interleaved cbc block crypt unit
// no dependencies
`default_nettype none
package icbc_pkg;

  localparam int NumRounds = 8;
  localparam int RowWords = 6;
  localparam int NumRows = NumRounds + 1;
  localparam int InvSteps = 16;

  localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW = 2'd1;
  localparam logic [1:0] CFG_DIRECTION = 2'd2;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END = 1'b1;

  localparam logic [2:0] STAT_OK = 3'd0;
  localparam logic [2:0] STAT_NO_DATA = 3'd1;
  localparam logic [2:0] STAT_PARTIAL = 3'd2;
  localparam logic [2:0] STAT_BAD_TRAILER = 3'd3;
  localparam logic [2:0] STAT_LEN_MISMATCH = 3'd4;

  localparam logic [63:0] KEY_HIGH_RST = 64'h0000_0001_0002_0003;
  localparam logic [63:0] KEY_LOW_RST = 64'h0004_0005_0006_0007;

  typedef enum logic [1:0] {
    STEP_MIX,
    STEP_MUL1,
    STEP_MUL2,
    STEP_OUT
  } step_t;

  typedef enum logic [1:0] {
    KOP_COPY,
    KOP_NEG,
    KOP_INV
  } ks_op_t;

  typedef struct packed {
    logic [5:0] idx;
    ks_op_t op;
  } ks_src_t;

  typedef struct packed {
    logic accept;
    logic load_x;
    logic step;
    step_t step_kind;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic use_cipher;
    logic has_result;
    logic out_free;
  } dp_status_t;

  // multiplication modulo 2^16+1, zero stands for 2^16
  function automatic logic [15:0] mmul(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] p;
    logic [15:0] lo;
    logic [15:0] hi;
    p = {16'b0, a} * {16'b0, b};
    lo = p[15:0];
    hi = p[31:16];
    if (a == 16'd0) begin
      return 16'd1 - b;
    end else if (b == 16'd0) begin
      return 16'd1 - a;
    end else begin
      return lo - hi + {15'b0, (lo < hi)};
    end
  endfunction

  // expanded key word idx: key rotated left by 25 per group of eight
  function automatic logic [15:0] ek_word(input logic [127:0] key, input logic [5:0] idx);
    logic [127:0] rot;
    logic [127:0] sh;
    case (idx[5:3])
      3'd0: rot = key;
      3'd1: rot = {key[102:0], key[127:103]};
      3'd2: rot = {key[77:0], key[127:78]};
      3'd3: rot = {key[52:0], key[127:53]};
      3'd4: rot = {key[27:0], key[127:28]};
      3'd5: rot = {key[2:0], key[127:3]};
      3'd6: rot = {key[105:0], key[127:106]};
      default: rot = key;
    endcase
    sh = rot >> {(3'd7 - idx[2:0]), 4'b0000};
    return sh[15:0];
  endfunction

  // source word and operation of decrypt subkey at row r, column c
  function automatic ks_src_t dec_src(input logic [3:0] r, input logic [2:0] c);
    int b;
    int i;
    logic edge_row;
    ks_src_t s;
    b = 48 - 6 * int'(r);
    edge_row = (r == 4'd0) || (r == 4'd8);
    s.op = KOP_COPY;
    case (c)
      3'd0: begin i = b; s.op = KOP_INV; end
      3'd1: begin i = edge_row ? b + 1 : b + 2; s.op = KOP_NEG; end
      3'd2: begin i = edge_row ? b + 2 : b + 1; s.op = KOP_NEG; end
      3'd3: begin i = b + 3; s.op = KOP_INV; end
      3'd4: i = b - 2;
      3'd5: i = b - 1;
      default: i = 0;
    endcase
    s.idx = 6'(i);
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: sv/icbc_keysched.sv
// configuration registers and subkey schedule with iterative modular inverse
// depends on icbc_pkg
`default_nettype none
module icbc_keysched import icbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic [3:0]  rd_row,
  output logic [95:0]      row_data,
  output logic             dir,
  output logic             busy
);

  typedef enum logic [2:0] {
    KS_IDLE = 3'b001,
    KS_WORD = 3'b010,
    KS_INV  = 3'b100
  } ks_state_t;

  ks_state_t state_r, state_nxt;
  logic [63:0] key_hi_r, key_lo_r;
  logic dir_r;
  logic [3:0] row_r, row_nxt;
  logic [2:0] col_r, col_nxt;
  logic [15:0] base_r, base_nxt, acc_r, acc_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [95:0] sk_r [NumRows];

  ks_src_t src;
  logic [15:0] word, acc_mul;
  logic wr_en, last_word, cfg_hit;
  logic [15:0] wr_data;

  assign cfg_hit = cfg_we && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW ||
                              cfg_index == CFG_DIRECTION);
  assign src = dir_r ? dec_src(row_r, col_r)
                     : ks_src_t'{idx: ({2'b0, row_r} * 6'd6) + {3'b0, col_r}, op: KOP_COPY};
  assign word = ek_word({key_hi_r, key_lo_r}, src.idx);
  assign acc_mul = mmul(acc_r, base_r);
  assign last_word = (row_r == 4'(NumRows - 1)) && (col_r == 3'd3);

  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r;
    col_nxt = col_r;
    base_nxt = base_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    wr_en = 1'b0;
    wr_data = word;
    case (state_r)
      KS_WORD: begin
        case (src.op)
          KOP_INV: begin
            base_nxt = word;
            acc_nxt = 16'd1;
            cnt_nxt = 4'd0;
            state_nxt = KS_INV;
          end
          KOP_NEG: begin wr_en = 1'b1; wr_data = 16'd0 - word; end
          default: wr_en = 1'b1;
        endcase
      end
      KS_INV: begin
        if (cnt_r == 4'(InvSteps - 1)) begin
          wr_en = 1'b1;
          wr_data = acc_mul;
          state_nxt = KS_WORD;
        end else begin
          acc_nxt = acc_mul;
          base_nxt = mmul(base_r, base_r);
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      default: ;
    endcase
    if (wr_en) begin
      if (last_word) begin
        state_nxt = KS_IDLE;
      end else if (col_r == 3'(RowWords - 1)) begin
        row_nxt = row_r + 4'd1;
        col_nxt = 3'd0;
      end else begin
        col_nxt = col_r + 3'd1;
      end
    end
    if (cfg_hit) begin
      state_nxt = KS_WORD;
      row_nxt = 4'd0;
      col_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KS_WORD;
      row_r <= 4'd0;
      col_r <= 3'd0;
      key_hi_r <= KEY_HIGH_RST;
      key_lo_r <= KEY_LOW_RST;
      dir_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (cfg_we && cfg_index == CFG_KEY_HIGH) key_hi_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_KEY_LOW) key_lo_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_DIRECTION) dir_r <= cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    if (wr_en && !cfg_hit) sk_r[row_r][{col_r, 4'b0000} +: 16] <= wr_data;
  end

  assign row_data = sk_r[rd_row];
  assign dir = dir_r;
  assign busy = (state_r != KS_IDLE);

endmodule
`default_nettype wire

FILE: sv/icbc_ctrl.sv
// controller: item sequencing and round stepping of the shared round unit
// depends on icbc_pkg
`default_nettype none
module icbc_ctrl import icbc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       ks_busy,
  input  wire dp_status_t st,
  output logic            in_tready,
  output dp_cmd_t         cmd,
  output logic [3:0]      sk_row
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_RND    = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] rnd_r, rnd_nxt;
  logic [1:0] ph_r, ph_nxt;

  assign in_tready = (state_r == S_IDLE) && !ks_busy;
  assign sk_row = rnd_r;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt = rnd_r;
    ph_nxt = ph_r;
    cmd = '0;
    cmd.step_kind = STEP_MIX;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.accept = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        rnd_nxt = 4'd0;
        ph_nxt = 2'd0;
        if (st.use_cipher) begin
          cmd.load_x = 1'b1;
          state_nxt = S_RND;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_RND: begin
        cmd.step = 1'b1;
        if (rnd_r == 4'(NumRounds)) begin
          cmd.step_kind = STEP_OUT;
          state_nxt = S_FINISH;
        end else begin
          case (ph_r)
            2'd0: begin cmd.step_kind = STEP_MIX; ph_nxt = 2'd1; end
            2'd1: begin cmd.step_kind = STEP_MUL1; ph_nxt = 2'd2; end
            default: begin
              cmd.step_kind = STEP_MUL2;
              ph_nxt = 2'd0;
              rnd_nxt = rnd_r + 4'd1;
            end
          endcase
        end
      end
      S_FINISH: begin
        if (!st.has_result || st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r <= 4'd0;
      ph_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      rnd_r <= rnd_nxt;
      ph_r <= ph_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/icbc_datapath.sv
// datapath: input latch, round unit, cbc chaining, trailer checks and output register
// depends on icbc_pkg
`default_nettype none
module icbc_datapath import icbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  input  wire logic        restart,
  input  wire logic        dir,
  input  wire logic [95:0] row_data,
  input  wire logic [71:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        out_tready,
  output dp_status_t       st,
  output logic             out_tvalid,
  output logic [71:0]      out_tdata,
  output logic [2:0]       out_tuser,
  output logic             out_tlast
);

  logic op_r;
  logic [63:0] blk_r;
  logic [3:0] bc_r;
  logic [15:0] x1_r, x2_r, x3_r, x4_r, t0_r;
  logic [15:0] x1_nxt, x2_nxt, x3_nxt, x4_nxt, t0_nxt;
  logic [63:0] chain_r [2];
  logic [63:0] chain_nxt [2];
  logic phase_r, phase_nxt;
  logic [31:0] total_r, total_nxt;
  logic [63:0] held_r [2];
  logic [63:0] held_nxt [2];
  logic [1:0] seen_r, seen_nxt;
  logic out_valid_r;
  logic [63:0] out_blk_r;
  logic [3:0] out_cnt_r;
  logic [2:0] out_stat_r;
  logic out_end_r;

  logic [3:0] bc_in;
  logic [15:0] k0, k1, k2, k3, k4, k5, t1, ta;
  logic [63:0] mask, cin, xcat, plain, trail;
  logic [31:0] tot_add;
  logic [32:0] len;
  logic [32:0] len_diff;
  logic trail_ok;
  logic has, res_end, wipe;
  logic [63:0] res_blk;
  logic [3:0] res_cnt;
  logic [2:0] res_stat;

  assign bc_in = (in_tdata[67:64] > 4'd8) ? 4'd8 : in_tdata[67:64];
  assign {k5, k4, k3, k2, k1, k0} = row_data;
  assign mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> {bc_r, 3'b000});
  assign xcat = {x1_r, x2_r, x3_r, x4_r};

  always_comb begin
    if (dir) begin
      cin = blk_r;
    end else if (op_r == OP_DATA) begin
      cin = (blk_r & mask) ^ chain_r[phase_r];
    end else begin
      cin = {29'b0, total_r, 3'b000} ^ chain_r[phase_r];
    end
  end

  assign st.use_cipher = (op_r == OP_DATA) ? ((bc_r != 4'd0) && (!dir || bc_r == 4'd8))
                                           : !dir;
  assign st.out_free = !out_valid_r || out_tready;

  // round unit
  always_comb begin
    x1_nxt = x1_r;
    x2_nxt = x2_r;
    x3_nxt = x3_r;
    x4_nxt = x4_r;
    t0_nxt = t0_r;
    t1 = mmul(k5, t0_r + (x2_r ^ x4_r));
    ta = t0_r + t1;
    if (cmd.load_x) begin
      {x1_nxt, x2_nxt, x3_nxt, x4_nxt} = cin;
    end else if (cmd.step) begin
      case (cmd.step_kind)
        STEP_MIX: begin
          x1_nxt = mmul(x1_r, k0);
          x2_nxt = x2_r + k1;
          x3_nxt = x3_r + k2;
          x4_nxt = mmul(x4_r, k3);
        end
        STEP_MUL1: t0_nxt = mmul(k4, x1_r ^ x3_r);
        STEP_MUL2: begin
          x1_nxt = x1_r ^ t1;
          x4_nxt = x4_r ^ ta;
          x2_nxt = x3_r ^ t1;
          x3_nxt = ta ^ x2_r;
        end
        default: begin
          x1_nxt = mmul(x1_r, k0);
          x2_nxt = x3_r + k1;
          x3_nxt = x2_r + k2;
          x4_nxt = mmul(x4_r, k3);
        end
      endcase
    end
  end

  // end of item: chaining, held blocks and result
  always_comb begin
    chain_nxt = chain_r;
    held_nxt = held_r;
    phase_nxt = phase_r;
    total_nxt = total_r;
    seen_nxt = seen_r;
    has = 1'b0;
    res_end = 1'b0;
    wipe = 1'b0;
    res_blk = 64'd0;
    res_cnt = 4'd0;
    res_stat = STAT_OK;
    tot_add = total_r + {28'b0, bc_r};
    plain = xcat ^ chain_r[~phase_r];
    trail = (seen_r == 2'd1) ? held_r[0] : held_r[1];
    trail_ok = (trail[63:35] == 29'd0) && (trail[2:0] == 3'd0);
    len = {1'b0, trail[34:3]} + 33'd16;
    len_diff = len - {1'b0, total_r};
    if (op_r == OP_DATA) begin
      if (bc_r != 4'd0) begin
        if (!dir) begin
          total_nxt = tot_add;
          phase_nxt = ~phase_r;
          chain_nxt[~phase_r] = xcat;
          has = 1'b1;
          res_blk = xcat;
          res_cnt = 4'd8;
        end else if (bc_r != 4'd8) begin
          has = 1'b1;
          res_end = 1'b1;
          res_stat = STAT_PARTIAL;
        end else begin
          total_nxt = tot_add;
          chain_nxt[phase_r] = blk_r;
          phase_nxt = ~phase_r;
          if (seen_r < 2'd2) begin
            held_nxt[seen_r[0]] = plain;
            seen_nxt = seen_r + 2'd1;
          end else begin
            has = 1'b1;
            res_blk = held_r[0];
            res_cnt = 4'd8;
            held_nxt[0] = held_r[1];
            held_nxt[1] = plain;
          end
        end
      end
    end else begin
      has = 1'b1;
      res_end = 1'b1;
      if (!dir) begin
        res_blk = xcat;
        res_cnt = 4'd8;
      end else if (seen_r == 2'd0) begin
        res_stat = STAT_NO_DATA;
      end else if (!trail_ok) begin
        res_stat = STAT_BAD_TRAILER;
      end else if (seen_r == 2'd1) begin
        if (trail[34:3] != 32'd0) res_stat = STAT_LEN_MISMATCH;
      end else if (({1'b0, total_r} < len) && (len <= {1'b0, total_r} + 33'd8)) begin
        res_blk = held_r[0];
        res_cnt = len_diff[3:0];
      end else begin
        res_stat = STAT_LEN_MISMATCH;
      end
    end
    wipe = res_end;
  end

  assign st.has_result = has;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r[0] <= 64'd0;
      chain_r[1] <= 64'd0;
      phase_r <= 1'b0;
      total_r <= 32'd0;
      seen_r <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (restart || (cmd.finish && wipe)) begin
        chain_r[0] <= 64'd0;
        chain_r[1] <= 64'd0;
        phase_r <= 1'b0;
        total_r <= 32'd0;
        seen_r <= 2'd0;
      end else if (cmd.finish) begin
        chain_r <= chain_nxt;
        phase_r <= phase_nxt;
        total_r <= total_nxt;
        seen_r <= seen_nxt;
      end
      if (cmd.finish && has) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_tuser;
      blk_r <= in_tdata[63:0];
      bc_r <= bc_in;
    end
    x1_r <= x1_nxt;
    x2_r <= x2_nxt;
    x3_r <= x3_nxt;
    x4_r <= x4_nxt;
    t0_r <= t0_nxt;
    if (cmd.finish) held_r <= held_nxt;
    if (cmd.finish && has) begin
      out_blk_r <= res_blk;
      out_cnt_r <= res_cnt;
      out_stat_r <= res_stat;
      out_end_r <= res_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {4'b0, out_cnt_r, out_blk_r};
  assign out_tuser = out_stat_r;
  assign out_tlast = out_end_r;

endmodule
`default_nettype wire

FILE: sv/interleaved_cbc_block_crypt_unit.sv
// top level: block cipher in two-way interleaved cbc mode over a byte stream
// depends on icbc_pkg, icbc_keysched, icbc_ctrl, icbc_datapath
//
// input stream: in_tdata carries an eight-byte block (first byte on top) and its byte
// count, in_tuser is 0 for data and 1 for end of stream. output stream: out_tdata
// carries the processed block and its valid byte count, out_tuser the status code,
// out_tlast marks the result that closes the stream.
// cfg_we/cfg_index/cfg_wdata write key high, key low and direction; a write restarts
// the stream and rebuilds the subkeys, during which in_tready stays low.
// a block that runs the cipher goes from transfer in to the output register through
// a decode step, eight rounds on the shared round unit, each in mix, first multiply
// and second multiply steps (three dependent modular multiplies), an output transform
// step and a finish step. items without cipher work pass the decode and finish steps
// only. one item is in flight at a time; a new item is taken once the last one finishes.
// after reset and after a configuration write the subkeys are rebuilt one word at a time,
// and for decrypt each modular inverse is computed by repeated squaring and multiplying.
// a stalled receiver holds the output register; the next item is still taken and
// waits in its finish cycle until the output register is free.
`default_nettype none
module interleaved_cbc_block_crypt_unit import icbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // data_block, byte_count, zero pad
  input  wire logic        in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // out_block, out_count, zero pad
  output logic [2:0]       out_tuser,  // status
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_status_t st;
  logic [3:0] sk_row;
  logic [95:0] row_data;
  logic dir, ks_busy, cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW ||
                              cfg_index == CFG_DIRECTION);

  icbc_keysched u_keysched (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .rd_row(sk_row), .row_data(row_data), .dir(dir), .busy(ks_busy)
  );

  icbc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .ks_busy(ks_busy),
    .st(st), .in_tready(in_tready), .cmd(cmd), .sk_row(sk_row)
  );

  icbc_datapath u_datapath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .restart(cfg_hit), .dir(dir),
    .row_data(row_data), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tready(out_tready), .st(st), .out_tvalid(out_tvalid),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  a_ready_keys: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !ks_busy) else $error("input taken while subkeys rebuild");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> !in_tready) else $error("input ready right after key write");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != STAT_OK) |-> (out_tdata == 72'd0 && out_tlast))
    else $error("error result not zero or not closing");

endmodule
`default_nettype wire

FILE: sim/interleaved_cbc_block_crypt_unit_tb.sv
// self-checking testbench for interleaved_cbc_block_crypt_unit: directed rows, then random
// encrypt and decrypt streams checked against an in-bench cipher and chaining predictor
// depends on icbc_pkg and the unit rtl
`timescale 1ns / 100ps
`default_nettype none
module interleaved_cbc_block_crypt_unit_tb import icbc_pkg::*;;

  localparam int IdlePct = 27;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 40;
  localparam int CycleLimit = 600000;
  localparam int ItemTarget = 850;

  typedef logic [15:0] subkey_t [52];

  typedef struct packed {
    logic        op;
    logic [63:0] blk;
    logic [3:0]  cnt;
  } item_t;

  typedef struct packed {
    logic [63:0] blk;
    logic [3:0]  cnt;
    logic        last;
    logic [2:0]  status;
  } result_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CFG,
    ROW_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        op;
    logic [63:0] blk;
    logic [3:0]  cnt;
    logic [1:0]  idx;
    logic [2:0]  status;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // data_block, byte_count, zero pad
  logic        in_tuser;   // op
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // out_block, out_count, zero pad
  logic [2:0]  out_tuser;  // status
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;

  interleaved_cbc_block_crypt_unit dut (.*);

  // predictor state
  logic [63:0] key_hi, key_lo;
  logic        decrypting;
  subkey_t     round_keys;
  logic [63:0] chain_val [2];
  logic        chain_sel;
  logic [31:0] bytes_in;
  logic [63:0] held_blk [2];
  int          held_cnt;

  result_t pending_results[$];
  int  fail_count;
  int  items_sent;
  int  results_seen;
  int  streams_sent;
  int  cycle_count;
  logic idle_on;
  logic hold_req;

  function automatic logic [15:0] mul_mod(input logic [15:0] a, input logic [15:0] b);
    logic [63:0] x, y;
    x = (a == 16'd0) ? 64'd65536 : {48'd0, a};
    y = (b == 16'd0) ? 64'd65536 : {48'd0, b};
    return 16'((x * y) % 64'd65537);
  endfunction

  function automatic logic [15:0] inv_mod(input logic [15:0] a);
    logic [63:0] base, r;
    base = (a == 16'd0) ? 64'd65536 : {48'd0, a};
    r = 64'd1;
    for (int i = 0; i < 16; i++) begin
      r = (r * base) % 64'd65537;
      base = (base * base) % 64'd65537;
    end
    return 16'(r);
  endfunction

  function automatic subkey_t make_subkeys(input logic [63:0] hi_in, input logic [63:0] lo_in,
                                           input logic dec);
    logic [15:0] ek [56];
    logic [63:0] hi, lo, nh, nl;
    subkey_t sk;
    int b;
    hi = hi_in;
    lo = lo_in;
    for (int g = 0; g < 7; g++) begin
      for (int w = 0; w < 4; w++) begin
        ek[g * 8 + w] = 16'(hi >> (48 - 16 * w));
        ek[g * 8 + 4 + w] = 16'(lo >> (48 - 16 * w));
      end
      nh = (hi << 25) | (lo >> 39);
      nl = (lo << 25) | (hi >> 39);
      hi = nh;
      lo = nl;
    end
    if (!dec) begin
      for (int i = 0; i < 52; i++) sk[i] = ek[i];
      return sk;
    end
    sk[0] = inv_mod(ek[48]);
    sk[1] = -ek[49];
    sk[2] = -ek[50];
    sk[3] = inv_mod(ek[51]);
    sk[4] = ek[46];
    sk[5] = ek[47];
    for (int r = 1; r < 8; r++) begin
      b = 48 - 6 * r;
      sk[6 * r] = inv_mod(ek[b]);
      sk[6 * r + 1] = -ek[b + 2];
      sk[6 * r + 2] = -ek[b + 1];
      sk[6 * r + 3] = inv_mod(ek[b + 3]);
      sk[6 * r + 4] = ek[b - 2];
      sk[6 * r + 5] = ek[b - 1];
    end
    sk[48] = inv_mod(ek[0]);
    sk[49] = -ek[1];
    sk[50] = -ek[2];
    sk[51] = inv_mod(ek[3]);
    return sk;
  endfunction

  function automatic logic [63:0] idea(input subkey_t k, input logic [63:0] blk);
    logic [15:0] x1, x2, x3, x4, t0, t1;
    x1 = blk[63:48];
    x2 = blk[47:32];
    x3 = blk[31:16];
    x4 = blk[15:0];
    for (int r = 0; r < 8; r++) begin
      x1 = mul_mod(x1, k[6 * r]);
      x2 = x2 + k[6 * r + 1];
      x3 = x3 + k[6 * r + 2];
      x4 = mul_mod(x4, k[6 * r + 3]);
      t0 = mul_mod(k[6 * r + 4], x1 ^ x3);
      t1 = mul_mod(k[6 * r + 5], t0 + (x2 ^ x4));
      t0 = t0 + t1;
      x1 = x1 ^ t1;
      x4 = x4 ^ t0;
      t0 = t0 ^ x2;
      x2 = x3 ^ t1;
      x3 = t0;
    end
    return {mul_mod(x1, k[48]), x3 + k[49], x2 + k[50], mul_mod(x4, k[51])};
  endfunction

  task automatic restart_chain();
    chain_val[0] = '0;
    chain_val[1] = '0;
    held_blk[0] = '0;
    held_blk[1] = '0;
    chain_sel = 1'b0;
    bytes_in = '0;
    held_cnt = 0;
  endtask

  task automatic push_result(input logic [63:0] blk, input logic [3:0] cnt, input logic last,
                             input logic [2:0] status);
    pending_results.push_back('{blk: blk, cnt: cnt, last: last, status: status});
    if (last) restart_chain();
  endtask

  function automatic logic [63:0] chain_encrypt(input logic [63:0] p);
    logic [63:0] c;
    c = idea(round_keys, p ^ chain_val[chain_sel]);
    chain_sel = ~chain_sel;
    chain_val[chain_sel] = c;
    return c;
  endfunction

  function automatic logic [63:0] chain_decrypt(input logic [63:0] c);
    logic [63:0] p;
    chain_val[chain_sel] = c;
    p = idea(round_keys, c);
    chain_sel = ~chain_sel;
    return p ^ chain_val[chain_sel];
  endfunction

  function automatic logic trailer_valid(input logic [63:0] t);
    return (t[63:35] == '0) && (t[2:0] == '0);
  endfunction

  task automatic predict_transfer(input item_t it);
    logic [3:0]  bc;
    logic [63:0] mask, p, t, old;
    logic [33:0] len, tot;
    bc = it.cnt;
    if (it.op == OP_DATA) begin
      if (bc == 4'd0) return;
      if (bc > 4'd8) bc = 4'd8;
      bytes_in = bytes_in + bc;
      if (!decrypting) begin
        mask = ~64'd0 << (64 - 8 * bc);
        push_result(chain_encrypt(it.blk & mask), 4'd8, 1'b0, STAT_OK);
      end else if (bc != 4'd8) begin
        push_result('0, 4'd0, 1'b1, STAT_PARTIAL);
      end else begin
        p = chain_decrypt(it.blk);
        if (held_cnt < 2) begin
          held_blk[held_cnt] = p;
          held_cnt++;
        end else begin
          old = held_blk[0];
          held_blk[0] = held_blk[1];
          held_blk[1] = p;
          push_result(old, 4'd8, 1'b0, STAT_OK);
        end
      end
    end else if (!decrypting) begin
      push_result(chain_encrypt({29'd0, bytes_in, 3'd0}), 4'd8, 1'b1, STAT_OK);
    end else if (held_cnt == 0) begin
      push_result('0, 4'd0, 1'b1, STAT_NO_DATA);
    end else if (held_cnt == 1) begin
      t = held_blk[0];
      if (!trailer_valid(t)) push_result('0, 4'd0, 1'b1, STAT_BAD_TRAILER);
      else if (t[63:3] != '0) push_result('0, 4'd0, 1'b1, STAT_LEN_MISMATCH);
      else push_result('0, 4'd0, 1'b1, STAT_OK);
    end else begin
      t = held_blk[1];
      if (!trailer_valid(t)) begin
        push_result('0, 4'd0, 1'b1, STAT_BAD_TRAILER);
      end else begin
        len = {2'b0, t[34:3]} + 34'd16;
        tot = {2'b0, bytes_in};
        if (tot < len && len <= tot + 34'd8) push_result(held_blk[0], 4'(len - tot), 1'b1, STAT_OK);
        else push_result('0, 4'd0, 1'b1, STAT_LEN_MISMATCH);
      end
    end
  endtask

  task automatic apply_cfg(input logic [1:0] idx, input logic [63:0] val);
    case (idx)
      CFG_KEY_HIGH: key_hi = val;
      CFG_KEY_LOW: key_lo = val;
      CFG_DIRECTION: decrypting = val[0];
      default: return;
    endcase
    round_keys = make_subkeys(key_hi, key_lo, decrypting);
    restart_chain();
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("** interleaved_cbc_block_crypt_unit: FAILED **");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected transfer blk=%h cnt=%0d last=%b status=%0d", $time,
                 out_tdata[63:0], out_tdata[67:64], out_tlast, out_tuser);
        fail_count <= fail_count + 1;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[63:0] !== want.blk || out_tdata[67:64] !== want.cnt ||
            out_tlast !== want.last || out_tuser !== want.status) begin
          $display("%0t mismatch expected blk=%h cnt=%0d last=%b status=%0d", $time,
                   want.blk, want.cnt, want.last, want.status);
          $display("%0t          actual   blk=%h cnt=%0d last=%b status=%0d", $time,
                   out_tdata[63:0], out_tdata[67:64], out_tlast, out_tuser);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  // receiver side backpressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (int i = 0; i < HoldCycles; i++) @(negedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else begin
        out_tready <= !(idle_on && $urandom_range(99) < IdlePct);
      end
    end
  end

  task automatic send_item(input item_t it);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IdlePct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.op;
    in_tdata <= {4'd0, it.cnt, it.blk};
    do @(posedge clk); while (!in_tready);
    predict_transfer(it);
    if (it.op == OP_END) streams_sent++;
    if (it.op == OP_END || it.cnt != 4'd0) items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [63:0] val);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_cfg(idx, val);
  endtask

  // one stream: in decrypt mode mostly valid ciphertext built with the current key
  task automatic send_stream();
    item_t       q[$];
    subkey_t     enc_keys;
    logic [63:0] prev, p;
    logic [31:0] ptotal;
    int          nblk, last_bc, style;
    nblk = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(5);
    style = $urandom_range(99);
    if (decrypting && style < 82) begin
      enc_keys = make_subkeys(key_hi, key_lo, 1'b0);
      prev = '0;
      ptotal = '0;
      for (int i = 0; i < nblk; i++) begin
        last_bc = (i == nblk - 1 && $urandom_range(1)) ? $urandom_range(1, 7) : 8;
        p = {$urandom, $urandom} & (~64'd0 << (64 - 8 * last_bc));
        ptotal += last_bc;
        prev = idea(enc_keys, p ^ prev);
        q.push_back('{op: OP_DATA, blk: prev, cnt: 4'd8});
      end
      prev = idea(enc_keys, {29'd0, ptotal, 3'd0} ^ prev);
      q.push_back('{op: OP_DATA, blk: prev, cnt: 4'd8});
      if (style < 10) q[$urandom_range(q.size() - 1)].blk[$urandom_range(63)] ^= 1'b1;
    end else begin
      for (int i = 0; i < nblk; i++) begin
        q.push_back('{op: OP_DATA, blk: {$urandom, $urandom}, cnt: 4'd8});
        if ($urandom_range(9) == 0) q[$].cnt = 4'($urandom_range(15));
      end
      if (nblk > 0 && $urandom_range(2) == 0) q[$].cnt = 4'($urandom_range(1, 7));
    end
    q.push_back('{op: OP_END, blk: {$urandom, $urandom}, cnt: 4'($urandom_range(15))});
    foreach (q[i]) send_item(q[i]);
  endtask

  row_t stim_rows [] = '{
    '{ROW_ITEM, OP_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 2'd0, STAT_OK},
    '{ROW_ITEM, OP_DATA, 64'h1234_5678_9ABC_DEF0, 4'd0, 2'd0, STAT_OK},
    '{ROW_ITEM, OP_DATA, 64'h0000_0000_0000_0000, 4'd15, 2'd0, STAT_OK},
    '{ROW_ITEM, OP_DATA, 64'hA5A5_A5A5_A5A5_A5A5, 4'd3, 2'd0, STAT_OK},
    '{ROW_ITEM, OP_DATA, 64'h0123_4567_89AB_CDEF, 4'd8, 2'd0, STAT_OK},
    '{ROW_ITEM, OP_END, 64'h0, 4'd0, 2'd0, STAT_OK},
    '{ROW_ITEM, OP_END, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 2'd0, STAT_OK},
    '{ROW_CFG, OP_DATA, 64'd1, 4'd0, CFG_DIRECTION, STAT_OK},
    '{ROW_TYPED, OP_END, 64'h0, 4'd8, 2'd0, STAT_NO_DATA},
    '{ROW_TYPED, OP_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 4'd5, 2'd0, STAT_PARTIAL},
    '{ROW_ITEM, OP_DATA, 64'h1111_2222_3333_4444, 4'd8, 2'd0, STAT_OK},
    '{ROW_ITEM, OP_END, 64'h0, 4'd0, 2'd0, STAT_OK},
    '{ROW_ITEM, OP_DATA, 64'h0, 4'd8, 2'd0, STAT_OK},
    '{ROW_ITEM, OP_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 2'd0, STAT_OK},
    '{ROW_ITEM, OP_DATA, 64'h5555_AAAA_5555_AAAA, 4'd8, 2'd0, STAT_OK},
    '{ROW_ITEM, OP_END, 64'h0, 4'd0, 2'd0, STAT_OK},
    '{ROW_CFG, OP_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, CFG_KEY_HIGH, STAT_OK},
    '{ROW_CFG, OP_DATA, 64'h0, 4'd0, CFG_KEY_LOW, STAT_OK},
    '{ROW_CFG, OP_DATA, 64'd0, 4'd0, CFG_DIRECTION, STAT_OK},
    '{ROW_ITEM, OP_DATA, 64'h8000_0000_0000_0001, 4'd8, 2'd0, STAT_OK},
    '{ROW_ITEM, OP_DATA, 64'hFF00_0000_0000_0000, 4'd1, 2'd0, STAT_OK},
    '{ROW_ITEM, OP_END, 64'h0, 4'd0, 2'd0, STAT_OK}
  };

  initial begin
    logic [63:0] v;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    fail_count = 0;
    items_sent = 0;
    results_seen = 0;
    streams_sent = 0;
    cycle_count = 0;
    key_hi = KEY_HIGH_RST;
    key_lo = KEY_LOW_RST;
    decrypting = 1'b0;
    round_keys = make_subkeys(key_hi, key_lo, 1'b0);
    restart_chain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        write_cfg(stim_rows[i].idx, stim_rows[i].blk);
      end else begin
        send_item('{op: stim_rows[i].op, blk: stim_rows[i].blk, cnt: stim_rows[i].cnt});
        if (stim_rows[i].kind == ROW_TYPED) begin
          void'(pending_results.pop_back());
          pending_results.push_back('{blk: '0, cnt: 4'd0, last: 1'b1,
                                      status: stim_rows[i].status});
        end
      end
    end

    for (int ph = 0; items_sent < ItemTarget; ph++) begin
      case (ph % 4)
        0: v = '0;
        1: v = ~64'd0;
        default: v = {$urandom, $urandom};
      endcase
      write_cfg(CFG_KEY_HIGH, v);
      write_cfg(CFG_KEY_LOW, (ph % 4 < 2) ? v : {$urandom, $urandom});
      write_cfg(CFG_DIRECTION, {63'd0, ph[0] ^ ph[2]});
      idle_on = (ph != 3);
      if (ph == 2) hold_req = 1'b1;
      repeat (30 + $urandom_range(10)) begin
        if (items_sent < ItemTarget) send_stream();
      end
    end

    wait_drained();
    $display("covered %0d items in %0d streams, %0d results checked, both directions",
             items_sent, streams_sent, results_seen);
    $display("keys all zero, all ones and random, with idle gaps and one long output stall");
    if (fail_count == 0) begin
      $display("** interleaved_cbc_block_crypt_unit: PASSED **");
    end else begin
      $display("** interleaved_cbc_block_crypt_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: interleaved_cbc_block_crypt_unit.f
sv/icbc_pkg.sv
sv/icbc_keysched.sv
sv/icbc_ctrl.sv
sv/icbc_datapath.sv
sv/interleaved_cbc_block_crypt_unit.sv
sim/interleaved_cbc_block_crypt_unit_tb.sv
